@@ src/atc_pkg.sv @@
// Package for the ambient temperature converter: register map, configuration
// struct, stream widths and the constant-divide helpers for the display values.
// No dependencies.
package atc_pkg;

    // Temperature encoding.
    localparam logic [15:0] UNKNOWN_TEMP = 16'hFFFF;
    localparam logic [15:0] TEMP_OFFSET  = 16'd4000;
    localparam logic [15:0] ROUND_BELOW  = 16'd49;
    localparam logic [15:0] ROUND_ABOVE  = 16'd50;
    localparam logic [15:0] ROUND_SAT    = UNKNOWN_TEMP - ROUND_ABOVE;

    // Reciprocal for floor(t / 100) with t below 2**16: (t * M) >> 24 is exact.
    localparam int          DIV100_SHIFT = 24;
    localparam logic [17:0] DIV100_MUL   = 18'd167773;

    // Reciprocal for floor(x / 5) with x below 2**20: (x * M) >> 22 is exact.
    localparam int          DIV5_SHIFT   = 22;
    localparam logic [19:0] DIV5_MUL     = 20'd838861;

    // Stream widths.
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 72;

    // Register map, one word per register at byte address 4 * index.
    localparam int APB_ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_SENSOR_SOURCE   = 3'd0,
        REG_DISPLAY_UNIT    = 3'd1,
        REG_ICE_HIGH_C      = 3'd2,
        REG_ICE_LOW_C       = 3'd3,
        REG_ICE_HIGH_F      = 3'd4,
        REG_ICE_LOW_F       = 3'd5,
        REG_MOVING_HIGH     = 3'd6,
        REG_MOVING_LOW      = 3'd7
    } atc_reg_idx_t;

    typedef struct packed {
        logic        sensor_source;
        logic        display_unit;
        logic [15:0] ice_high_celsius;
        logic [15:0] ice_low_celsius;
        logic [15:0] ice_high_fahrenheit;
        logic [15:0] ice_low_fahrenheit;
        logic [15:0] moving_speed_high;
        logic [15:0] moving_speed_low;
    } atc_cfg_t;

    // Truncate to a whole degree: floor(t / 100) * 100.
    function automatic logic [15:0] atc_trunc100(input logic [15:0] t);
        logic [33:0] prod;
        logic [9:0]  q;
        prod = 34'(t) * 34'(DIV100_MUL);
        q    = prod[DIV100_SHIFT +: 10];
        return 16'({q, 6'b0}) + 16'({q, 5'b0}) + 16'({q, 2'b0});
    endfunction

    // Round to a whole degree: 49 is added below the offset and 50 at or above it,
    // the top of the range saturates, and unknown stays unknown.
    function automatic logic [15:0] atc_round_disp(input logic [15:0] v);
        logic [15:0] t;
        if (v == UNKNOWN_TEMP) begin
            return UNKNOWN_TEMP;
        end
        if (v < TEMP_OFFSET) begin
            t = v + ROUND_BELOW;
        end else if (v < ROUND_SAT) begin
            t = v + ROUND_ABOVE;
        end else begin
            t = UNKNOWN_TEMP;
        end
        return atc_trunc100(t);
    endfunction

    // Fahrenheit in offset form: floor(c * 18 / 10) = floor(c * 9 / 5).
    function automatic logic [15:0] atc_fahr(input logic [15:0] c);
        logic [19:0] nine_c;
        logic [39:0] prod;
        logic [17:0] q;
        nine_c = 20'({c, 3'b0}) + 20'(c);
        prod   = 40'(nine_c) * 40'(DIV5_MUL);
        q      = prod[DIV5_SHIFT +: 18];
        if (c == UNKNOWN_TEMP || q >= 18'(UNKNOWN_TEMP)) begin
            return UNKNOWN_TEMP;
        end
        return q[15:0];
    endfunction

endpackage

@@ src/atc_regs.sv @@
// Configuration register file behind the APB-style port.
// Depends on atc_pkg for the register map and the configuration struct.
module atc_regs
    import atc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output atc_cfg_t              cfg
);

    atc_cfg_t     cfg_reg;
    atc_reg_idx_t idx;
    logic         wr_en;

    assign idx   = atc_reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    // Register writes happen in the access phase of a write transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sensor_source       <= 1'b1;
            cfg_reg.display_unit        <= 1'b0;
            cfg_reg.ice_high_celsius    <= 16'd4500;
            cfg_reg.ice_low_celsius     <= 16'd4300;
            cfg_reg.ice_high_fahrenheit <= 16'd8100;
            cfg_reg.ice_low_fahrenheit  <= 16'd7700;
            cfg_reg.moving_speed_high   <= 16'd500;
            cfg_reg.moving_speed_low    <= 16'd400;
        end else if (wr_en) begin
            unique case (idx)
                REG_SENSOR_SOURCE: cfg_reg.sensor_source       <= pwdata[0];
                REG_DISPLAY_UNIT:  cfg_reg.display_unit        <= pwdata[0];
                REG_ICE_HIGH_C:    cfg_reg.ice_high_celsius    <= pwdata[15:0];
                REG_ICE_LOW_C:     cfg_reg.ice_low_celsius     <= pwdata[15:0];
                REG_ICE_HIGH_F:    cfg_reg.ice_high_fahrenheit <= pwdata[15:0];
                REG_ICE_LOW_F:     cfg_reg.ice_low_fahrenheit  <= pwdata[15:0];
                REG_MOVING_HIGH:   cfg_reg.moving_speed_high   <= pwdata[15:0];
                REG_MOVING_LOW:    cfg_reg.moving_speed_low    <= pwdata[15:0];
            endcase
        end
    end

    // Read data returns the addressed register, zero extended.
    always_comb begin
        unique case (idx)
            REG_SENSOR_SOURCE: prdata = 32'(cfg_reg.sensor_source);
            REG_DISPLAY_UNIT:  prdata = 32'(cfg_reg.display_unit);
            REG_ICE_HIGH_C:    prdata = 32'(cfg_reg.ice_high_celsius);
            REG_ICE_LOW_C:     prdata = 32'(cfg_reg.ice_low_celsius);
            REG_ICE_HIGH_F:    prdata = 32'(cfg_reg.ice_high_fahrenheit);
            REG_ICE_LOW_F:     prdata = 32'(cfg_reg.ice_low_fahrenheit);
            REG_MOVING_HIGH:   prdata = 32'(cfg_reg.moving_speed_high);
            REG_MOVING_LOW:    prdata = 32'(cfg_reg.moving_speed_low);
        endcase
    end

endmodule

@@ src/ambient_temp_convert_ice_warn.sv @@
// Top level of the ambient temperature converter with ice and icy-road warnings.
// Depends on atc_pkg and atc_regs.
//
//   Channel   Direction  Handshake             Payload
//   s_axis    in         s_tvalid / s_tready   s_tdata, 40 bits
//   m_axis    out        m_tvalid / m_tready   m_tdata, 72 bits
//   apb       in         psel / penable        paddr, pwdata, prdata
//
// One item per cycle unless m_tready stalls it; an item passes three registers.
// The three registers are the input register, a stage holding the Fahrenheit value
// and the Celsius display, and the result register, which takes the Fahrenheit
// display and the updated moving and ice flags.
// Reset is synchronous and active low; it clears the stage valids and flags.
// A stalled result holds the output register; earlier stages keep accepting
// until they fill, so s_tready depends combinationally on m_tready.
module ambient_temp_convert_ice_warn
    import atc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Fields from bit 0: sensor_status[1:0], celsius_offset[17:2],
    // distance_mode_on[18], speed_valid[19], vehicle_speed[35:20], zero pad.
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // Fields from bit 0: status[1:0], celsius_instant[17:2],
    // fahrenheit_instant[33:18], celsius_display[49:34], fahrenheit_display[65:50],
    // ice_warn_celsius[66], ice_warn_fahrenheit[67], icy_road_celsius[68],
    // icy_road_fahrenheit[69], ice_warn_selected[70], icy_road_selected[71].
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    atc_cfg_t cfg;

    atc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    // Stage registers.
    logic        s1_valid_reg;
    logic [35:0] s1_data_reg;
    logic        s2_valid_reg;
    logic [1:0]  s2_status_reg;
    logic [15:0] s2_cel_reg;
    logic [15:0] s2_fah_reg;
    logic [15:0] s2_cdsp_reg;
    logic        s2_mode_reg;
    logic        s2_spd_ok_reg;
    logic [15:0] s2_spd_reg;
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    // Warning state.
    logic moving_reg, moving_next;
    logic ice_c_reg, ice_c_next;
    logic ice_f_reg, ice_f_next;

    logic out_free, s2_free, s1_free;

    // Each stage moves on when the next one is empty or moving on itself.
    assign out_free = !m_valid_reg || m_tready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s_tready = s1_free;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Stage 1 fields.
    logic [1:0]  s1_status;
    logic [15:0] s1_cel;
    logic [15:0] s1_cdsp;

    assign s1_status = s1_data_reg[1:0];
    assign s1_cel    = s1_data_reg[17:2];

    // Celsius display: bus sources truncate, analog sources round.
    always_comb begin
        if (s1_cel == UNKNOWN_TEMP) begin
            s1_cdsp = UNKNOWN_TEMP;
        end else if (!cfg.sensor_source) begin
            s1_cdsp = atc_trunc100(s1_cel);
        end else begin
            s1_cdsp = atc_round_disp(s1_cel);
        end
    end

    // Stage 2: Fahrenheit display and the flag updates.
    logic [15:0] s2_fdsp;
    logic        status_ok;
    logic        icy_c, icy_f;

    assign s2_fdsp   = atc_round_disp(s2_fah_reg);
    assign status_ok = (s2_status_reg == 2'd1);

    always_comb begin
        // Moving flag with speed hysteresis; the set test wins on overlap.
        moving_next = moving_reg;
        if (!s2_spd_ok_reg) begin
            moving_next = 1'b0;
        end else if (s2_spd_reg >= cfg.moving_speed_high) begin
            moving_next = 1'b1;
        end else if (s2_spd_reg <= cfg.moving_speed_low) begin
            moving_next = 1'b0;
        end

        // Ice flags with hysteresis; the clear test wins on overlap.
        ice_c_next = ice_c_reg;
        if (!status_ok || s2_cdsp_reg >= cfg.ice_high_celsius) begin
            ice_c_next = 1'b0;
        end else if (s2_cdsp_reg <= cfg.ice_low_celsius) begin
            ice_c_next = 1'b1;
        end

        ice_f_next = ice_f_reg;
        if (!status_ok || s2_fdsp >= cfg.ice_high_fahrenheit) begin
            ice_f_next = 1'b0;
        end else if (s2_fdsp <= cfg.ice_low_fahrenheit) begin
            ice_f_next = 1'b1;
        end
    end

    assign icy_c = s2_mode_reg && moving_next && ice_c_next;
    assign icy_f = s2_mode_reg && moving_next && ice_f_next;

    // Control registers: stage valids and warning state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            moving_reg   <= 1'b0;
            ice_c_reg    <= 1'b0;
            ice_f_reg    <= 1'b0;
        end else begin
            if (s1_free) begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_free) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_free) begin
                m_valid_reg <= s2_valid_reg;
            end
            if (out_free && s2_valid_reg) begin
                moving_reg <= moving_next;
                ice_c_reg  <= ice_c_next;
                ice_f_reg  <= ice_f_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s1_free) begin
            s1_data_reg <= s_tdata[35:0];
        end
        if (s2_free) begin
            s2_status_reg <= s1_status;
            s2_cel_reg    <= s1_cel;
            s2_fah_reg    <= atc_fahr(s1_cel);
            s2_cdsp_reg   <= s1_cdsp;
            s2_mode_reg   <= s1_data_reg[18];
            s2_spd_ok_reg <= s1_data_reg[19];
            s2_spd_reg    <= s1_data_reg[35:20];
        end
        if (out_free) begin
            m_data_reg <= {
                cfg.display_unit ? icy_f : icy_c,
                cfg.display_unit ? ice_f_next : ice_c_next,
                icy_f,
                icy_c,
                ice_f_next,
                ice_c_next,
                s2_fdsp,
                s2_cdsp_reg,
                s2_fah_reg,
                s2_cel_reg,
                s2_status_reg
            };
        end
    end

endmodule

@@ src/atc_checker.sv @@
// Port-level checks for the ambient temperature converter, bound to the top level.
// Depends on atc_pkg for the stream width and the unknown-temperature code.
module atc_checker
    import atc_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // An icy-road bit never stands without its ice warning.
    a_icy_needs_ice: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[68] || m_tdata[66]) && (!m_tdata[69] || m_tdata[67]))
        else $error("icy road without ice warning");

    // A status other than valid clears both ice warnings.
    a_status_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != 2'd1 |-> !m_tdata[66] && !m_tdata[67])
        else $error("ice warning with invalid status");

    // Unknown Celsius gives unknown Fahrenheit and unknown displays.
    a_unknown: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[17:2] == UNKNOWN_TEMP |->
            m_tdata[33:18] == UNKNOWN_TEMP && m_tdata[49:34] == UNKNOWN_TEMP
            && m_tdata[65:50] == UNKNOWN_TEMP)
        else $error("unknown temperature not carried through");

    // The selected warning pair is the Celsius pair or the Fahrenheit pair.
    a_selected: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[70] == m_tdata[66] && m_tdata[71] == m_tdata[68])
            || (m_tdata[70] == m_tdata[67] && m_tdata[71] == m_tdata[69]))
        else $error("selected warnings match neither unit");

endmodule

bind ambient_temp_convert_ice_warn atc_checker u_atc_checker (.*);

@@ sim/tb_ambient_temp_convert_ice_warn.sv @@
// Self-checking testbench for ambient_temp_convert_ice_warn: drives samples on the
// input stream, programs the registers over APB and checks every result transfer.
// Depends on atc_pkg and the block under src/.
`timescale 1ns / 100ps

module tb_ambient_temp_convert_ice_warn;
    import atc_pkg::*;

    // Input sample, packed exactly as s_tdata (first field in the lowest bits).
    typedef struct packed {
        logic [3:0]  pad;
        logic [15:0] vehicle_speed;
        logic        speed_valid;
        logic        distance_mode_on;
        logic [15:0] celsius_offset;
        logic [1:0]  sensor_status;
    } temp_sample_t;

    // Result, packed exactly as m_tdata.
    typedef struct packed {
        logic        icy_road_selected;
        logic        ice_warn_selected;
        logic        icy_road_fahrenheit;
        logic        icy_road_celsius;
        logic        ice_warn_fahrenheit;
        logic        ice_warn_celsius;
        logic [15:0] fahrenheit_display;
        logic [15:0] celsius_display;
        logic [15:0] fahrenheit_instant;
        logic [15:0] celsius_instant;
        logic [1:0]  status;
    } temp_report_t;

    // One row of the directed part; a typed row carries its result written out.
    typedef struct packed {
        logic         typed;
        temp_report_t want;
        temp_sample_t smp;
    } dir_row_t;

    localparam int PIPE_DEPTH   = 3;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_ITEMS  = 80;
    localparam int SHOW_LIMIT   = 10;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // Predictor copy of the registers and of the three flags.
    atc_cfg_t     cur_cfg;
    logic         moving_now;
    logic         ice_c_now;
    logic         ice_f_now;

    temp_report_t pending_reports[$];
    dir_row_t     dir_rows[$];
    temp_report_t oldest_report;

    int  fault_count = 0;
    int  samples_sent = 0;
    int  reports_checked = 0;
    int  icy_reports = 0;
    int  reg_writes = 0;
    int  settings_used = 0;
    bit  no_gaps = 1'b0;
    bit  hold_request = 1'b0;
    int  hold_left = 0;

    ambient_temp_convert_ice_warn DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 12 ns clock.
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #5_000_000;
        $display("Timeout with %0d results still outstanding.", pending_reports.size());
        $display("Some tests failed");
        $finish;
    end

    // Whole-degree display value: 49 is added below the offset, 50 at or above it,
    // the top of the range saturates and unknown stays unknown.
    function automatic logic [15:0] round_whole(logic [15:0] v);
        int unsigned t;
        if (v == UNKNOWN_TEMP) begin
            return UNKNOWN_TEMP;
        end
        if (v < TEMP_OFFSET) begin
            t = v + 49;
        end else if (v < 16'd65485) begin
            t = v + 50;
        end else begin
            t = 65535;
        end
        return 16'((t / 100) * 100);
    endfunction

    // Ice hysteresis: an invalid status clears, the clear level is checked first.
    function automatic logic ice_next(logic flag, logic ok, logic [15:0] dsp,
                                      logic [15:0] hi, logic [15:0] lo);
        if (!ok) begin
            return 1'b0;
        end
        if (dsp >= hi) begin
            return 1'b0;
        end
        if (dsp <= lo) begin
            return 1'b1;
        end
        return flag;
    endfunction

    // Works out the result of one sample and advances the flag state.
    function automatic temp_report_t convert_sample(temp_sample_t s);
        temp_report_t r;
        int unsigned  f;
        logic [15:0]  fah;
        logic [15:0]  cdsp;
        logic         icy_c;
        logic         icy_f;
        if (s.celsius_offset == UNKNOWN_TEMP) begin
            f = 65535;
        end else begin
            f = (int'(s.celsius_offset) * 18) / 10;
            if (f >= 65535) begin
                f = 65535;
            end
        end
        fah = 16'(f);
        if (s.celsius_offset == UNKNOWN_TEMP) begin
            cdsp = UNKNOWN_TEMP;
        end else if (!cur_cfg.sensor_source) begin
            cdsp = 16'((int'(s.celsius_offset) / 100) * 100);
        end else begin
            cdsp = round_whole(s.celsius_offset);
        end

        // Moving flag first: the set level wins when the levels overlap.
        if (!s.speed_valid) begin
            moving_now = 1'b0;
        end else if (s.vehicle_speed >= cur_cfg.moving_speed_high) begin
            moving_now = 1'b1;
        end else if (s.vehicle_speed <= cur_cfg.moving_speed_low) begin
            moving_now = 1'b0;
        end

        r.status             = s.sensor_status;
        r.celsius_instant    = s.celsius_offset;
        r.fahrenheit_instant = fah;
        r.celsius_display    = cdsp;
        r.fahrenheit_display = round_whole(fah);
        ice_c_now = ice_next(ice_c_now, s.sensor_status == 2'd1, cdsp,
                             cur_cfg.ice_high_celsius, cur_cfg.ice_low_celsius);
        ice_f_now = ice_next(ice_f_now, s.sensor_status == 2'd1, r.fahrenheit_display,
                             cur_cfg.ice_high_fahrenheit, cur_cfg.ice_low_fahrenheit);
        icy_c = s.distance_mode_on && moving_now && ice_c_now;
        icy_f = s.distance_mode_on && moving_now && ice_f_now;
        r.ice_warn_celsius    = ice_c_now;
        r.ice_warn_fahrenheit = ice_f_now;
        r.icy_road_celsius    = icy_c;
        r.icy_road_fahrenheit = icy_f;
        r.ice_warn_selected   = cur_cfg.display_unit ? ice_f_now : ice_c_now;
        r.icy_road_selected   = cur_cfg.display_unit ? icy_f : icy_c;
        return r;
    endfunction

    function automatic logic [15:0] clamp16(int v);
        if (v < 0) begin
            return 16'd0;
        end
        if (v > 65535) begin
            return 16'hFFFF;
        end
        return 16'(v);
    endfunction

    // Random sample, mostly near the active thresholds so the hysteresis moves.
    function automatic temp_sample_t draw_sample();
        temp_sample_t s;
        int           pick;
        int           base;
        s.pad = '0;
        pick = $urandom_range(99);
        if (pick < 45) begin
            base = $urandom_range(1) ? cur_cfg.ice_low_celsius : cur_cfg.ice_high_celsius;
            s.celsius_offset = clamp16(base + $urandom_range(500) - 250);
        end else if (pick < 65) begin
            base = $urandom_range(1) ? cur_cfg.ice_low_fahrenheit
                                     : cur_cfg.ice_high_fahrenheit;
            s.celsius_offset = clamp16(base * 10 / 18 + $urandom_range(400) - 200);
        end else if (pick < 85) begin
            s.celsius_offset = 16'($urandom);
        end else begin
            case ($urandom_range(8))
                0: s.celsius_offset = 16'hFFFF;
                1: s.celsius_offset = 16'hFFFE;
                2: s.celsius_offset = 16'd3999;
                3: s.celsius_offset = 16'd4000;
                4: s.celsius_offset = 16'd0;
                5: s.celsius_offset = 16'd65484;
                6: s.celsius_offset = 16'd65485;
                7: s.celsius_offset = 16'd36408;
                default: s.celsius_offset = 16'd36409;
            endcase
        end
        s.sensor_status = ($urandom_range(99) < 85) ? 2'd1 : 2'($urandom_range(3));
        pick = $urandom_range(99);
        if (pick < 60) begin
            base = $urandom_range(1) ? cur_cfg.moving_speed_low : cur_cfg.moving_speed_high;
            s.vehicle_speed = clamp16(base + $urandom_range(300) - 150);
        end else if (pick < 90) begin
            s.vehicle_speed = 16'($urandom);
        end else begin
            s.vehicle_speed = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        end
        s.speed_valid      = ($urandom_range(99) < 90);
        s.distance_mode_on = ($urandom_range(99) < 75);
        return s;
    endfunction

    task automatic add_row(logic [1:0] st, logic [15:0] cel, logic mode, logic sv,
                           logic [15:0] spd, logic typed, temp_report_t want_r);
        dir_row_t row;
        row.smp   = {4'b0, spd, sv, mode, cel, st};
        row.typed = typed;
        row.want  = want_r;
        dir_rows.push_back(row);
    endtask

    // Offers one sample, with random gaps, and records its result once accepted.
    task automatic send_sample(temp_sample_t smp, logic typed, temp_report_t typed_r);
        temp_report_t predicted;
        while (!no_gaps && $urandom_range(99) < 21) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        do @(posedge aclk); while (!s_tready);
        predicted = convert_sample(smp);
        pending_reports.push_back(typed ? typed_r : predicted);
        samples_sent++;
    endtask

    // Stops offering and waits until every result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) begin
            @(posedge aclk);
        end
        repeat (PIPE_DEPTH + 2) @(posedge aclk);
    endtask

    // APB write: a setup phase, an access phase, then the bus returns to idle.
    task automatic write_reg(atc_reg_idx_t idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SENSOR_SOURCE: cur_cfg.sensor_source       = val[0];
            REG_DISPLAY_UNIT:  cur_cfg.display_unit        = val[0];
            REG_ICE_HIGH_C:    cur_cfg.ice_high_celsius    = val[15:0];
            REG_ICE_LOW_C:     cur_cfg.ice_low_celsius     = val[15:0];
            REG_ICE_HIGH_F:    cur_cfg.ice_high_fahrenheit = val[15:0];
            REG_ICE_LOW_F:     cur_cfg.ice_low_fahrenheit  = val[15:0];
            REG_MOVING_HIGH:   cur_cfg.moving_speed_high   = val[15:0];
            REG_MOVING_LOW:    cur_cfg.moving_speed_low    = val[15:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge aclk);
    endtask

    // Writes every register; unused upper data bits carry noise.
    task automatic apply_settings(atc_cfg_t c);
        write_reg(REG_SENSOR_SOURCE, {31'($urandom), c.sensor_source});
        write_reg(REG_DISPLAY_UNIT,  {31'($urandom), c.display_unit});
        write_reg(REG_ICE_HIGH_C,    {16'($urandom), c.ice_high_celsius});
        write_reg(REG_ICE_LOW_C,     {16'($urandom), c.ice_low_celsius});
        write_reg(REG_ICE_HIGH_F,    {16'($urandom), c.ice_high_fahrenheit});
        write_reg(REG_ICE_LOW_F,     {16'($urandom), c.ice_low_fahrenheit});
        write_reg(REG_MOVING_HIGH,   {16'($urandom), c.moving_speed_high});
        write_reg(REG_MOVING_LOW,    {16'($urandom), c.moving_speed_low});
        settings_used++;
    endtask

    task automatic cmp_field(string name, logic [15:0] want_v, logic [15:0] got_v);
        if (got_v !== want_v) begin
            fault_count++;
            if (fault_count <= SHOW_LIMIT) begin
                $display("Mismatch in %s of result %0d: expected %0d, got %0d",
                         name, reports_checked, want_v, got_v);
            end
        end
    endtask

    task automatic compare_report(temp_report_t w, temp_report_t g);
        cmp_field("status", 16'(w.status), 16'(g.status));
        cmp_field("celsius_instant", w.celsius_instant, g.celsius_instant);
        cmp_field("fahrenheit_instant", w.fahrenheit_instant, g.fahrenheit_instant);
        cmp_field("celsius_display", w.celsius_display, g.celsius_display);
        cmp_field("fahrenheit_display", w.fahrenheit_display, g.fahrenheit_display);
        cmp_field("ice_warn_celsius", 16'(w.ice_warn_celsius), 16'(g.ice_warn_celsius));
        cmp_field("ice_warn_fahrenheit", 16'(w.ice_warn_fahrenheit),
                  16'(g.ice_warn_fahrenheit));
        cmp_field("icy_road_celsius", 16'(w.icy_road_celsius), 16'(g.icy_road_celsius));
        cmp_field("icy_road_fahrenheit", 16'(w.icy_road_fahrenheit),
                  16'(g.icy_road_fahrenheit));
        cmp_field("ice_warn_selected", 16'(w.ice_warn_selected), 16'(g.ice_warn_selected));
        cmp_field("icy_road_selected", 16'(w.icy_road_selected), 16'(g.icy_road_selected));
    endtask

    // Result side: every transfer is checked against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                fault_count++;
                if (fault_count <= SHOW_LIMIT) begin
                    $display("Result transfer with nothing expected: %h", m_tdata);
                end
            end else begin
                oldest_report = pending_reports.pop_front();
                compare_report(oldest_report, temp_report_t'(m_tdata));
                if (oldest_report.icy_road_selected) begin
                    icy_reports++;
                end
                reports_checked++;
            end
        end
    end

    // Receiver: random stalls, a quiet stretch on request, and one long hold-off.
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (!no_gaps && $urandom_range(99) < 21) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
            @(posedge aclk);
        end
    end

    // Main sequence: reset, directed rows, then random phases under new settings.
    initial begin
        atc_cfg_t next_cfg;
        int       p;
        int       n;

        cur_cfg.sensor_source       = 1'b1;
        cur_cfg.display_unit        = 1'b0;
        cur_cfg.ice_high_celsius    = 16'd4500;
        cur_cfg.ice_low_celsius     = 16'd4300;
        cur_cfg.ice_high_fahrenheit = 16'd8100;
        cur_cfg.ice_low_fahrenheit  = 16'd7700;
        cur_cfg.moving_speed_high   = 16'd500;
        cur_cfg.moving_speed_low    = 16'd400;
        moving_now = 1'b0;
        ice_c_now  = 1'b0;
        ice_f_now  = 1'b0;

        // Typed results are written MSB first: six flags (selected icy, selected
        // ice, icy F, icy C, ice F, ice C), F display, C display, F, C, status.
        // Unknown temperature with unknown status, speed invalid.
        add_row(2'd0, 16'hFFFF, 1'b0, 1'b0, 16'd0, 1'b1,
                {6'b000000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd0});
        // Status code 3 passes through and clears the ice flags; full speed.
        add_row(2'd3, 16'd0, 1'b1, 1'b1, 16'hFFFF, 1'b1,
                {6'b000000, 16'd0, 16'd0, 16'd0, 16'd0, 2'd3});
        // Coldest valid reading while moving: every warning is raised.
        add_row(2'd1, 16'd0, 1'b1, 1'b1, 16'hFFFF, 1'b1,
                {6'b111111, 16'd0, 16'd0, 16'd0, 16'd0, 2'd1});
        // Hottest known reading: Fahrenheit overflows to unknown, display saturates.
        add_row(2'd1, 16'd65534, 1'b1, 1'b1, 16'hFFFF, 1'b1,
                {6'b000000, 16'hFFFF, 16'd65500, 16'hFFFF, 16'd65534, 2'd1});
        // Failed sensor at exactly the offset.
        add_row(2'd2, 16'd4000, 1'b0, 1'b0, 16'd0, 1'b1,
                {6'b000000, 16'd7200, 16'd4000, 16'd7200, 16'd4000, 2'd2});
        // Rounding around the offset and the speed hysteresis edges.
        add_row(2'd1, 16'd3951, 1'b1, 1'b1, 16'd500, 1'b0, '0);
        add_row(2'd1, 16'd3950, 1'b1, 1'b1, 16'd450, 1'b0, '0);
        add_row(2'd1, 16'd4349, 1'b1, 1'b1, 16'd400, 1'b0, '0);
        add_row(2'd1, 16'd4450, 1'b1, 1'b1, 16'd501, 1'b0, '0);
        add_row(2'd1, 16'd4420, 1'b1, 1'b1, 16'd450, 1'b0, '0);
        add_row(2'd1, 16'd4300, 1'b1, 1'b1, 16'd450, 1'b0, '0);
        // Unknown temperature with a valid status is compared like any value.
        add_row(2'd1, 16'hFFFF, 1'b1, 1'b1, 16'd450, 1'b0, '0);
        add_row(2'd1, 16'd65484, 1'b0, 1'b1, 16'd300, 1'b0, '0);
        add_row(2'd1, 16'd65485, 1'b1, 1'b1, 16'd700, 1'b0, '0);
        // Largest Fahrenheit that stays known, and the first that does not.
        add_row(2'd1, 16'd36408, 1'b1, 1'b1, 16'd700, 1'b0, '0);
        add_row(2'd1, 16'd36409, 1'b1, 1'b1, 16'd700, 1'b0, '0);
        // Speed invalid while fast clears the moving flag.
        add_row(2'd1, 16'd3999, 1'b1, 1'b0, 16'hFFFF, 1'b0, '0);
        add_row(2'd1, 16'd1, 1'b1, 1'b1, 16'd0, 1'b0, '0);
        // Fahrenheit set level, clear level, then in between.
        add_row(2'd1, 16'd4278, 1'b1, 1'b1, 16'hFFFF, 1'b0, '0);
        add_row(2'd1, 16'd4478, 1'b1, 1'b1, 16'hFFFF, 1'b0, '0);
        add_row(2'd1, 16'd4444, 1'b1, 1'b1, 16'hFFFF, 1'b0, '0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            send_sample(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);
        end
        drain();

        for (p = 1; p <= PHASE_COUNT; p++) begin
            next_cfg = cur_cfg;
            case (p)
                1: begin
                    next_cfg.sensor_source = 1'b0;
                    next_cfg.display_unit  = 1'b1;
                end
                2: begin
                    next_cfg = '0;
                    next_cfg.sensor_source = 1'b1;
                end
                3: begin
                    next_cfg = '1;
                    next_cfg.sensor_source = 1'b0;
                    next_cfg.display_unit  = 1'b0;
                end
                4: begin
                    // Overlapping levels: clear wins for ice, set wins for moving.
                    next_cfg.sensor_source       = 1'b1;
                    next_cfg.display_unit        = 1'b1;
                    next_cfg.ice_high_celsius    = 16'd4300;
                    next_cfg.ice_low_celsius     = 16'd4600;
                    next_cfg.ice_high_fahrenheit = 16'd7700;
                    next_cfg.ice_low_fahrenheit  = 16'd8200;
                    next_cfg.moving_speed_high   = 16'd400;
                    next_cfg.moving_speed_low    = 16'd600;
                end
                5: begin
                    next_cfg.sensor_source       = 1'b0;
                    next_cfg.display_unit        = 1'b1;
                    next_cfg.ice_high_celsius    = 16'd4500;
                    next_cfg.ice_low_celsius     = 16'd4300;
                    next_cfg.ice_high_fahrenheit = 16'd8100;
                    next_cfg.ice_low_fahrenheit  = 16'd7700;
                    next_cfg.moving_speed_high   = 16'd500;
                    next_cfg.moving_speed_low    = 16'd400;
                end
                default: begin
                    next_cfg.sensor_source       = 1'($urandom_range(1));
                    next_cfg.display_unit        = 1'($urandom_range(1));
                    next_cfg.ice_low_celsius     = 16'($urandom_range(3000, 6000));
                    next_cfg.ice_high_celsius    = 16'(next_cfg.ice_low_celsius
                                                        + $urandom_range(600));
                    next_cfg.ice_low_fahrenheit  = 16'($urandom_range(6000, 10000));
                    next_cfg.ice_high_fahrenheit = 16'(next_cfg.ice_low_fahrenheit
                                                        + $urandom_range(600));
                    next_cfg.moving_speed_low    = 16'($urandom_range(2000));
                    next_cfg.moving_speed_high   = 16'(next_cfg.moving_speed_low
                                                        + $urandom_range(400));
                end
            endcase
            apply_settings(next_cfg);

            // Phase 4 runs without any gaps on either side.
            no_gaps = (p == 4);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 5 && n == 10) begin
                    hold_request = 1'b1;
                end
                send_sample(draw_sample(), 1'b0, '0);
            end
            no_gaps = 1'b0;
            drain();
        end

        $display("Run covered %0d samples and %0d checked results under %0d settings",
                 samples_sent, reports_checked, settings_used + 1);
        $display("(%0d register writes, %0d results with the icy-road warning set).",
                 reg_writes, icy_reports);
        if (fault_count == 0 && pending_reports.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/atc_pkg.sv
src/atc_regs.sv
src/ambient_temp_convert_ice_warn.sv
src/atc_checker.sv
sim/tb_ambient_temp_convert_ice_warn.sv
